>>> rtl/vpi_pkg.sv
// ----------------------------------------------------------------------------
// vpi_pkg: shared types and constants of the Verlet particle integrator
// Widths, register map and the request and response word layouts.
// ----------------------------------------------------------------------------
package vpi_pkg;

   localparam int NumParticles = 1024;
   localparam int MaxDims      = 3;
   localparam int IdxW         = 10;
   localparam int AddrW        = $clog2(NumParticles);

   typedef enum logic [1:0] {
      REG_ACTIVE_DIMS    = 2'd0,
      REG_FORCE_SCALE    = 2'd1,
      REG_VELOCITY_SCALE = 2'd2,
      REG_HALF_MASS      = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef struct packed {
      logic               op;
      logic [IdxW-1:0]    particle;
      logic signed [31:0] load_pos_x;
      logic signed [31:0] load_pos_y;
      logic signed [31:0] load_pos_z;
      logic signed [31:0] load_prev_x;
      logic signed [31:0] load_prev_y;
      logic signed [31:0] load_prev_z;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] drift_x;
      logic signed [31:0] drift_y;
      logic signed [31:0] drift_z;
      logic [63:0]        kinetic_energy;
   } rsp_word_type;

   typedef struct packed {
      logic [95:0] pos;
      logic [95:0] prev;
      logic [95:0] drift;
   } entry_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647)       r = 32'sh7fffffff;
      else if (v < -36'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

endpackage

>>> rtl/vpi_stream_if.sv
// ----------------------------------------------------------------------------
// vpi_stream_if: valid/ready channel
// Carries one word per handshake from source to sink.
// ----------------------------------------------------------------------------
interface vpi_stream_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/verlet_particle_integrator.sv
// ----------------------------------------------------------------------------
// verlet_particle_integrator: position Verlet update over a particle table
// Load and step words for up to 1024 particles, Q16.16 state kept in one
// on-chip memory, one row per particle.
// ----------------------------------------------------------------------------
// One word per cycle is accepted unless stalled; a word's response passes the
// memory read, new position, velocity product, square sum, energy product and
// response register stages. A response held by a low rsp ready stalls the
// whole pipeline. The particle memory has one read and one write port; a word
// that hits a particle still in flight takes its state from the forwarding
// path, so back-to-back steps of the same particle are exact. No clearing pass
// is run after reset; a particle must be loaded before it is stepped. The user
// must have configuration written via the csr_ port while idle; not enforced.
module verlet_particle_integrator
   import vpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   vpi_stream_if.sink   req,
   vpi_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int Depth = 6;

   logic [1:0]  dims_ff;
   logic [31:0] fscale_ff, vscale_ff, hmass_ff;
   logic [1:0]  reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff   <= 2'd3;
         fscale_ff <= 32'd65536;
         vscale_ff <= 32'd32768;
         hmass_ff  <= 32'd32768;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_index_type'(reg_sel))
            REG_ACTIVE_DIMS:    dims_ff   <= csr_pwdata[1:0];
            REG_FORCE_SCALE:    fscale_ff <= csr_pwdata;
            REG_VELOCITY_SCALE: vscale_ff <= csr_pwdata;
            REG_HALF_MASS:      hmass_ff  <= csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(reg_sel))
         REG_ACTIVE_DIMS:    csr_prdata = {30'd0, dims_ff};
         REG_FORCE_SCALE:    csr_prdata = fscale_ff;
         REG_VELOCITY_SCALE: csr_prdata = vscale_ff;
         REG_HALF_MASS:      csr_prdata = hmass_ff;
      endcase
   end

   // pipeline: s1 read, s2 new pos + force product, s3 velocity product,
   // s4 square sum, s5 energy product, s6 response register
   logic adv;
   logic [Depth:1] vld_ff, vld_in;
   logic out_full;

   assign out_full  = vld_ff[Depth];
   assign adv       = !out_full || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = out_full;

   always_comb begin
      vld_in = vld_ff;
      if (adv) vld_in = {vld_ff[Depth-1:1], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   entry_type mem [NumParticles];
   entry_type rd_ff;
   logic       wr_en;
   logic [AddrW-1:0] wr_addr;
   entry_type  wr_data;

   always_ff @(posedge clock) begin
      if (adv) rd_ff <= mem[req.data.particle[AddrW-1:0]];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // stage 1 to 5 request word and 3-D flag registers
   req_word_type w1_ff, w2_ff, w3_ff, w4_ff, w5_ff;
   logic         d3_1_ff, d3_2_ff, d3_3_ff, d3_4_ff, d3_5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         w1_ff <= req.data; d3_1_ff <= (dims_ff == 2'd3);
         w2_ff <= w1_ff;    d3_2_ff <= d3_1_ff;
         w3_ff <= w2_ff;    d3_3_ff <= d3_2_ff;
         w4_ff <= w3_ff;    d3_4_ff <= d3_3_ff;
         w5_ff <= w4_ff;    d3_5_ff <= d3_4_ff;
      end
   end

   // entry computed at s2 is final; forward from s2..s6 results
   entry_type e2_ff, e3_ff, e4_ff, e5_ff, e6_ff;
   logic [AddrW-1:0] a2, a3, a4, a5, a6;
   logic ok1, ok2, ok3, ok4, ok5, ok6;
   logic [Depth:2] okv_ff;
   assign a2 = w2_ff.particle[AddrW-1:0];
   assign a3 = w3_ff.particle[AddrW-1:0];
   assign a4 = w4_ff.particle[AddrW-1:0];
   assign a5 = w5_ff.particle[AddrW-1:0];

   logic [AddrW-1:0] a6_ff;
   assign a6 = a6_ff;
   assign ok1 = vld_ff[1] && (int'(w1_ff.particle) < NumParticles);
   assign ok2 = okv_ff[2]; assign ok3 = okv_ff[3]; assign ok4 = okv_ff[4];
   assign ok5 = okv_ff[5]; assign ok6 = okv_ff[6];

   entry_type cur;
   logic [AddrW-1:0] a1;
   assign a1 = w1_ff.particle[AddrW-1:0];
   always_comb begin
      priority if (ok2 && a2 == a1) cur = e2_ff;
      else if (ok3 && a3 == a1) cur = e3_ff;
      else if (ok4 && a4 == a1) cur = e4_ff;
      else if (ok5 && a5 == a1) cur = e5_ff;
      else if (ok6 && a6 == a1) cur = e6_ff;
      else cur = rd_ff;
   end

   // s1 -> s2 compute new position per dimension, or take the load values
   entry_type e_in;
   logic signed [33:0] diff_n [3];
   always_comb begin
      logic signed [31:0] pos, prev, f, np, dr;
      logic signed [63:0] pr, fq;
      logic signed [35:0] acc;
      e_in = cur;
      for (int i = 0; i < 3; i++) begin
         pos  = cur.pos[95-32*i -: 32];
         prev = cur.prev[95-32*i -: 32];
         dr   = cur.drift[95-32*i -: 32];
         f    = (i == 0) ? w1_ff.force_x : (i == 1) ? w1_ff.force_y : w1_ff.force_z;
         pr   = f * $signed({1'b0, fscale_ff});
         fq   = pr >>> 16;
         if (fq > 64'sd17179869184)       fq = 64'sd17179869184;
         else if (fq < -64'sd17179869184) fq = -64'sd17179869184;
         acc  = 36'(pos) * 2 - 36'(prev) + 36'(fq);
         np   = sat32(acc);
         diff_n[i] = 34'(np) - 34'(prev);
         if (w1_ff.op == OP_LOAD) begin
            e_in.pos[95-32*i -: 32] = (i == 0) ? w1_ff.load_pos_x :
               (i == 1) ? w1_ff.load_pos_y : w1_ff.load_pos_z;
            e_in.prev[95-32*i -: 32] = (i == 0) ? w1_ff.load_prev_x :
               (i == 1) ? w1_ff.load_prev_y : w1_ff.load_prev_z;
            e_in.drift[95-32*i -: 32] = '0;
            diff_n[i] = '0;
         end else if (i < 2 || d3_1_ff) begin
            e_in.pos[95-32*i -: 32]   = np;
            e_in.prev[95-32*i -: 32]  = pos;
            e_in.drift[95-32*i -: 32] = sat32(36'(dr) + 36'(np) - 36'(pos));
         end else begin
            diff_n[i] = '0;
         end
      end
   end

   logic signed [33:0] diff_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         e2_ff <= e_in; e3_ff <= e2_ff; e4_ff <= e3_ff;
         e5_ff <= e4_ff; e6_ff <= e5_ff; a6_ff <= a5;
         diff_ff <= diff_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    okv_ff <= '0;
      else if (adv) okv_ff <= {okv_ff[Depth-1:2], ok1};
   end

   assign wr_en   = adv && ok2;
   assign wr_addr = a2;
   assign wr_data = e2_ff;

   // s2 -> s3 velocity
   logic signed [31:0] vel_ff [3];
   always_ff @(posedge clock) begin
      logic signed [66:0] vp;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            vp = diff_ff[i] * $signed({1'b0, vscale_ff});
            vel_ff[i] <= sat32(36'(vp >>> 16 > 67'sd34359738367 ? 67'sd34359738367 :
               vp >>> 16 < -67'sd34359738368 ? -67'sd34359738368 : vp >>> 16));
         end
      end
   end

   // s3 -> s4 sum of squares (absolute values up to 2^31, sum < 2^64)
   logic [63:0] sum_ff;
   logic signed [31:0] vel4_ff [3], vel5_ff [3];
   always_ff @(posedge clock) begin
      logic [31:0] m [3];
      if (adv) begin
         for (int i = 0; i < 3; i++)
            m[i] = vel_ff[i][31] ? 32'(-33'(vel_ff[i])) : vel_ff[i];
         sum_ff <= {32'd0, m[0]} * {32'd0, m[0]} + {32'd0, m[1]} * {32'd0, m[1]} +
                   {32'd0, m[2]} * {32'd0, m[2]};
         vel4_ff <= vel_ff;
      end
   end

   // s4 -> s5 energy: two 32x32 partial products
   logic [63:0] ph_ff, pl_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff <= sum_ff[63:32] * hmass_ff;
         pl_ff <= sum_ff[31:0]  * hmass_ff;
         vel5_ff <= vel4_ff;
      end
   end

   logic [63:0] ke_n;
   logic [64:0] ke_s;
   assign ke_s = {1'b0, ph_ff[47:0], 16'd0} + 65'(pl_ff[63:16]);
   assign ke_n = (ph_ff[63:48] != '0 || ke_s[64]) ? '1 : ke_s[63:0];

   // s5 -> s6 response register
   rsp_word_type r_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         if (!ok5) r_ff <= '0;
         else begin
            r_ff.pos_x   <= e5_ff.pos[95:64];
            r_ff.pos_y   <= e5_ff.pos[63:32];
            r_ff.pos_z   <= e5_ff.pos[31:0];
            r_ff.drift_x <= e5_ff.drift[95:64];
            r_ff.drift_y <= e5_ff.drift[63:32];
            r_ff.drift_z <= e5_ff.drift[31:0];
            r_ff.vel_x   <= w5_ff.op == OP_STEP ? vel5_ff[0] : '0;
            r_ff.vel_y   <= w5_ff.op == OP_STEP ? vel5_ff[1] : '0;
            r_ff.vel_z   <= w5_ff.op == OP_STEP && d3_5_ff ? vel5_ff[2] : '0;
            r_ff.kinetic_energy <= w5_ff.op == OP_STEP ? ke_n : '0;
         end
      end
   end

   assign rsp.data = r_ff;

endmodule

>>> rtl/vpi_checker.sv
// ----------------------------------------------------------------------------
// vpi_checker: port-level checks for the particle integrator
// Watches handshakes and response content over time.
// ----------------------------------------------------------------------------
module vpi_checker
   import vpi_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data,
   input logic         csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline stalled");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind verlet_particle_integrator vpi_checker u_vpi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_data   (rsp.data),
   .csr_pready (csr_pready)
);
